// ===== rtl/core/buffer_frame_lru_manager_macros.svh =====
// Assertion macros for the buffer frame LRU manager.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BUFFER_FRAME_LRU_MANAGER_MACROS_SVH
`define BUFFER_FRAME_LRU_MANAGER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define BFLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define BFLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bflm_pkg.sv =====
// Shared types and constants for the buffer frame LRU manager.
// No dependencies; used by bflm_ctrl, bflm_dpath and the top level.
`default_nettype none

package bflm_pkg;

    localparam int FRAMES     = 64;
    localparam int STAMP_BITS = 32;
    localparam int PIN_BITS   = 16;
    localparam int PAGE_BITS  = 32;
    localparam int FRAME_AW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    typedef logic [FRAME_AW-1:0]   t_addr;
    typedef logic [5:0]            t_frame_idx;
    typedef logic [PAGE_BITS-1:0]  t_page;
    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [PIN_BITS-1:0]   t_pin;

    typedef enum logic [2:0] {
        OP_EVICT   = 3'd0,
        OP_CONNECT = 3'd1,
        OP_PIN     = 3'd2,
        OP_UNPIN   = 3'd3,
        OP_ERASE   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EV_OUT,
        ST_RD,
        ST_RMW
    } t_state;

    // Per-frame record kept in memory.
    typedef struct packed {
        t_page  page;
        t_stamp stamp;
        t_pin   pin;
    } t_rec;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture the transaction, arm the scan
        logic scan_rd;  // read the record at the scan address, advance it
        logic rmw_rd;   // read the target frame record
        logic rmw_wr;   // update the target frame, load the result
        logic ev_out;   // load the evict result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_last; // scan address sits on the last frame
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/bflm_ctrl.sv =====
// Sequencer for the buffer frame LRU manager.
// Depends on bflm_pkg; drives bflm_dpath through t_cmd and reads t_stat back.
`default_nettype none

module bflm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic [2:0]      i_opcode,
    input  wire bflm_pkg::t_stat i_stat,
    output bflm_pkg::t_cmd       o_cmd,
    output logic                 busy
);

    bflm_pkg::t_state r_state;
    bflm_pkg::t_state n_state;
    logic             accept;

    assign accept = start && (r_state == bflm_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bflm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bflm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_opcode == bflm_pkg::OP_EVICT) ? bflm_pkg::ST_SCAN
                                                               : bflm_pkg::ST_RD;
                end
            end
            bflm_pkg::ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = bflm_pkg::ST_DRAIN;
                end
            end
            bflm_pkg::ST_DRAIN:  n_state = bflm_pkg::ST_EV_OUT;
            bflm_pkg::ST_EV_OUT: n_state = bflm_pkg::ST_IDLE;
            bflm_pkg::ST_RD:     n_state = bflm_pkg::ST_RMW;
            bflm_pkg::ST_RMW:    n_state = bflm_pkg::ST_IDLE;
            default:             n_state = bflm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            bflm_pkg::ST_IDLE:   o_cmd.load    = accept;
            bflm_pkg::ST_SCAN:   o_cmd.scan_rd = 1'b1;
            bflm_pkg::ST_DRAIN:  o_cmd         = '0;
            bflm_pkg::ST_EV_OUT: o_cmd.ev_out  = 1'b1;
            bflm_pkg::ST_RD:     o_cmd.rmw_rd  = 1'b1;
            bflm_pkg::ST_RMW:    o_cmd.rmw_wr  = 1'b1;
            default:             o_cmd         = '0;
        endcase
    end

    assign busy = (r_state != bflm_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/bflm_dpath.sv =====
// Datapath for the buffer frame LRU manager: frame record memory, per-frame
// flags, stamp counter, scan compare and read-modify-write update.
// Depends on bflm_pkg; commanded by bflm_ctrl.
`default_nettype none

module bflm_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bflm_pkg::t_cmd i_cmd,
    output bflm_pkg::t_stat     o_stat,
    input  wire logic [2:0]     i_opcode,
    input  wire logic [5:0]     i_frame_index,
    input  wire logic [31:0]    i_page_number,
    input  wire logic           i_is_read,
    output logic                o_strobe,
    output logic                o_victim_found,
    output logic [5:0]          o_victim_frame,
    output logic [31:0]         o_victim_page,
    output logic                o_victim_page_valid,
    output logic                o_dirty_flag,
    output logic                o_unpin_error
);

    // Record memory; entries never written read as zero through r_init.
    bflm_pkg::t_rec r_mem [bflm_pkg::FRAMES];
    bflm_pkg::t_rec r_rdata;
    logic           r_rd_init;
    logic [bflm_pkg::FRAMES-1:0] r_init;
    logic [bflm_pkg::FRAMES-1:0] r_valid;
    logic [bflm_pkg::FRAMES-1:0] r_dirty;

    bflm_pkg::t_stamp     r_stamp_ctr;

    // Captured transaction
    logic [2:0]           r_op;
    bflm_pkg::t_page      r_page;
    logic                 r_is_read;
    logic                 r_ok;
    bflm_pkg::t_addr      r_faddr;

    // Scan state
    bflm_pkg::t_addr      r_scan_addr;
    bflm_pkg::t_addr      r_cmp_idx;
    logic                 r_cmp_vld;
    logic                 r_stop;
    bflm_pkg::t_stamp     r_best;
    logic                 r_found;
    bflm_pkg::t_addr      r_vframe;
    bflm_pkg::t_page      r_vpage;
    logic                 r_vvalid;

    // Result registers
    logic                 r_strobe;
    logic                 r_o_found;
    bflm_pkg::t_frame_idx r_o_vframe;
    bflm_pkg::t_page      r_o_vpage;
    logic                 r_o_vvalid;
    logic                 r_o_dirty;
    logic                 r_o_uerr;

    bflm_pkg::t_rec       eff;
    logic                 rd_en;
    bflm_pkg::t_addr      rd_addr;
    logic                 hit;

    bflm_pkg::t_rec       n_rec;
    logic                 n_valid_bit;
    logic                 n_dirty_bit;
    bflm_pkg::t_stamp     n_stamp_ctr;
    logic                 n_uerr;
    logic                 wr_en;

    assign eff = r_rd_init ? r_rdata : '0;

    assign rd_en   = i_cmd.scan_rd || i_cmd.rmw_rd;
    assign rd_addr = i_cmd.scan_rd ? r_scan_addr : r_faddr;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_faddr] <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_stamp_ctr <= '0;
            r_rd_init   <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_init <= r_init[rd_addr];
            end
            if (wr_en) begin
                r_init[r_faddr]  <= 1'b1;
                r_valid[r_faddr] <= n_valid_bit;
                r_dirty[r_faddr] <= n_dirty_bit;
            end
            if (i_cmd.rmw_wr) begin
                r_stamp_ctr <= n_stamp_ctr;
            end
        end
    end

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_opcode;
            r_page    <= i_page_number;
            r_is_read <= i_is_read;
            r_ok      <= (32'(i_frame_index) < 32'(bflm_pkg::FRAMES));
            r_faddr   <= bflm_pkg::t_addr'(i_frame_index);
        end
    end

    // Scan: compare runs in the cycle after the read of its address
    assign hit = r_cmp_vld && !r_stop && (eff.pin == '0) && (eff.stamp <= r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scan_addr <= '0;
            r_stop      <= 1'b0;
            r_best      <= r_stamp_ctr;
            r_found     <= 1'b0;
            r_vframe    <= '0;
            r_vpage     <= '0;
            r_vvalid    <= 1'b0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_scan_addr <= r_scan_addr + 1'b1;
                r_cmp_idx   <= r_scan_addr;
            end
            if (hit) begin
                r_found  <= 1'b1;
                r_vframe <= r_cmp_idx;
                r_best   <= eff.stamp;
                r_vpage  <= eff.page;
                r_vvalid <= r_valid[r_cmp_idx];
                // stop at the first empty unpinned frame
                r_stop   <= !r_valid[r_cmp_idx];
            end
        end
    end

    assign o_stat.scan_last = (r_scan_addr == bflm_pkg::t_addr'(bflm_pkg::FRAMES - 1));

    // Read-modify-write of the target frame
    always_comb begin
        n_rec       = eff;
        n_valid_bit = r_valid[r_faddr];
        n_dirty_bit = r_dirty[r_faddr];
        n_stamp_ctr = r_stamp_ctr;
        n_uerr      = 1'b0;
        wr_en       = 1'b0;
        if (r_ok) begin
            case (r_op)
                bflm_pkg::OP_CONNECT: begin
                    n_rec.page  = r_page;
                    n_valid_bit = 1'b1;
                    wr_en       = i_cmd.rmw_wr;
                end
                bflm_pkg::OP_PIN: begin
                    if (r_stamp_ctr != '1) begin
                        n_stamp_ctr = r_stamp_ctr + 1'b1;
                    end
                    n_rec.stamp = n_stamp_ctr;
                    if (eff.pin != '1) begin
                        n_rec.pin = eff.pin + 1'b1;
                    end
                    if (!r_is_read) begin
                        n_dirty_bit = 1'b1;
                    end
                    wr_en = i_cmd.rmw_wr;
                end
                bflm_pkg::OP_UNPIN: begin
                    if (r_stamp_ctr != '1) begin
                        n_stamp_ctr = r_stamp_ctr + 1'b1;
                    end
                    if (eff.pin == '0) begin
                        n_uerr = 1'b1;
                    end else begin
                        n_rec.pin = eff.pin - 1'b1;
                    end
                    wr_en = i_cmd.rmw_wr;
                end
                bflm_pkg::OP_ERASE: begin
                    n_rec       = '0;
                    n_valid_bit = 1'b0;
                    n_dirty_bit = 1'b0;
                    wr_en       = i_cmd.rmw_wr;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.ev_out || i_cmd.rmw_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_out) begin
            r_o_found  <= r_found;
            r_o_vframe <= bflm_pkg::t_frame_idx'(r_vframe);
            r_o_vpage  <= r_vpage;
            r_o_vvalid <= r_vvalid;
            r_o_dirty  <= r_ok && r_dirty[r_faddr];
            r_o_uerr   <= 1'b0;
        end else if (i_cmd.rmw_wr) begin
            r_o_found  <= 1'b0;
            r_o_vframe <= '0;
            r_o_vpage  <= '0;
            r_o_vvalid <= 1'b0;
            r_o_dirty  <= r_ok && n_dirty_bit;
            r_o_uerr   <= n_uerr;
        end
    end

    assign o_strobe            = r_strobe;
    assign o_victim_found      = r_o_found;
    assign o_victim_frame      = r_o_vframe;
    assign o_victim_page       = r_o_vpage;
    assign o_victim_page_valid = r_o_vvalid;
    assign o_dirty_flag        = r_o_dirty;
    assign o_unpin_error       = r_o_uerr;

endmodule

`default_nettype wire

// ===== rtl/core/buffer_frame_lru_manager.sv =====
// Top level of the buffer frame LRU manager: pin-count aware least-recently
// pinned victim selection over a pool of frame records.
// Depends on bflm_pkg, bflm_ctrl, bflm_dpath and the assertion macro header.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+---------------------------------------
//  request   | start in, busy out       | i_opcode, i_frame_index, i_page_number,
//            |                          | i_is_read
//  result    | o_strobe out, one cycle  | o_victim_found, o_victim_frame,
//            |                          | o_victim_page, o_victim_page_valid,
//            |                          | o_dirty_flag, o_unpin_error
//
// A transaction is taken when start is high and busy is low. Evict sweeps the
// record memory through its single read port, one frame per cycle, then goes
// through a drain state and an output state; the strobe is registered from the latter.
// Connect, pin, unpin and erase are one read-modify-write of the target frame,
// a read state and a write state. busy is high from the cycle after
// acceptance until the result is loaded; the strobe cycle may accept again.
// Reset (synchronous, active low) clears control, flags and the stamp counter
// at once; record memory is masked by per-frame written bits, so there is no
// clearing pass. Results cannot be stalled; each is shown for one cycle only.
`default_nettype none

`include "buffer_frame_lru_manager_macros.svh"

module buffer_frame_lru_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [5:0]  i_frame_index,
    input  wire logic [31:0] i_page_number,
    input  wire logic        i_is_read,
    output logic             o_strobe,
    output logic             o_victim_found,
    output logic [5:0]       o_victim_frame,
    output logic [31:0]      o_victim_page,
    output logic             o_victim_page_valid,
    output logic             o_dirty_flag,
    output logic             o_unpin_error
);

    bflm_pkg::t_cmd  cmd;
    bflm_pkg::t_stat stat;

    // Sequence the transaction: scan for evict, read-modify-write otherwise
    bflm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Hold frame records, run the compare and the update, register results
    bflm_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_opcode            (i_opcode),
        .i_frame_index       (i_frame_index),
        .i_page_number       (i_page_number),
        .i_is_read           (i_is_read),
        .o_strobe            (o_strobe),
        .o_victim_found      (o_victim_found),
        .o_victim_frame      (o_victim_frame),
        .o_victim_page       (o_victim_page),
        .o_victim_page_valid (o_victim_page_valid),
        .o_dirty_flag        (o_dirty_flag),
        .o_unpin_error       (o_unpin_error)
    );

    // An accepted transaction keeps the block busy in the next cycle
    `BFLM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept did not raise busy")
    // A result only closes out work that held the block busy
    `BFLM_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy), "strobe without prior work")
    // No victim means all victim fields read zero
    `BFLM_ASSERT_NOW(a_no_victim_zero, i_clk, i_rst_n, o_strobe && !o_victim_found, (o_victim_frame == 6'd0) && (o_victim_page == 32'd0) && !o_victim_page_valid, "victim fields set without victim")
    // Evict and unpin results never mix
    `BFLM_ASSERT_NOW(a_victim_no_uerr, i_clk, i_rst_n, o_strobe && o_victim_found, !o_unpin_error, "unpin error on evict result")

endmodule

`default_nettype wire
